// File: hw/rtl/per_bin_time_median_filter_macros.svh
// ---------------------------------------------------------------------------
// per_bin_time_median_filter_macros.svh
// Assertion macros used by the median filter RTL.
// ---------------------------------------------------------------------------
`ifndef PER_BIN_TIME_MEDIAN_FILTER_MACROS_SVH
`define PER_BIN_TIME_MEDIAN_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// plain invariant, sampled on clk_i, off while in reset
`define PTMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define PTMF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PTMF_ASSERT(lbl, prop, msg)
`define PTMF_ASSERT_IMP(lbl, ante, cons, msg)
`define PTMF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: hw/rtl/ptmf_pkg.sv
// ---------------------------------------------------------------------------
// ptmf_pkg
// Types and constants of the per-bin time median filter.
// ---------------------------------------------------------------------------
package ptmf_pkg;

  localparam int MAX_BINS    = 1024;
  localparam int MAX_KERNEL  = 32;
  localparam int SAMPLE_BITS = 16;

  // port widths fixed by the interface
  localparam int MAG_W = 16;
  localparam int OBIN_W = 10;

  localparam int BIN_W  = $clog2(MAX_BINS);
  localparam int FS_W   = $clog2(MAX_BINS + 1);
  localparam int SLOT_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int KLEN_W = $clog2(MAX_KERNEL + 1);
  localparam int ADDR_W = BIN_W + SLOT_W;
  localparam int DEPTH  = MAX_BINS * MAX_KERNEL;

  // sort buffer: odd length so both median taps sit at fixed places
  localparam int SORT_N = MAX_KERNEL + 1 + (MAX_KERNEL % 2);
  localparam int MID    = (SORT_N - 1) / 2;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = (FS_W > KLEN_W) ? FS_W : KLEN_W;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_LEN = CFG_IDX_W'(1);

  localparam logic [FS_W-1:0]   FS_RESET  = FS_W'(1024);
  localparam logic [FS_W-1:0]   FS_MIN    = FS_W'(2);
  localparam logic [FS_W-1:0]   FS_MAX    = FS_W'(MAX_BINS);
  localparam logic [KLEN_W-1:0] KLEN_RESET = KLEN_W'(17);
  localparam logic [KLEN_W-1:0] KLEN_MIN  = KLEN_W'(1);
  localparam logic [KLEN_W-1:0] KLEN_MAX  = KLEN_W'(MAX_KERNEL);

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  // sequencer -> sort buffer
  typedef struct packed {
    logic    init;  // preload pads for a new window
    logic    ins;   // insert val this cycle
    sample_t val;
  } sort_ctrl_t;

endpackage

// File: hw/rtl/ptmf_if.sv
// ---------------------------------------------------------------------------
// ptmf_if
// Valid/ready channels of the median filter: magnitudes in, medians out.
// ---------------------------------------------------------------------------
interface ptmf_in_if import ptmf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] magnitude;

  modport source (output valid, output magnitude, input ready);
  modport sink   (input valid, input magnitude, output ready);
endinterface

interface ptmf_out_if import ptmf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MAG_W-1:0]  median_value;
  logic [OBIN_W-1:0] bin_index;
  logic              frame_end;

  modport source (output valid, output median_value, output bin_index, output frame_end,
                  input ready);
  modport sink   (input valid, input median_value, input bin_index, input frame_end,
                  output ready);
endinterface

// File: hw/rtl/ptmf_hist_mem.sv
// ---------------------------------------------------------------------------
// ptmf_hist_mem
// Per-bin history ring: one write port, one registered read port.
// ---------------------------------------------------------------------------
module ptmf_hist_mem import ptmf_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  sample_t           wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output sample_t           rdata_o
);

  sample_t mem [DEPTH];
  sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ptmf_sorter.sv
// ---------------------------------------------------------------------------
// ptmf_sorter
// Insertion sort buffer, one value per cycle, with fixed median taps.
// ---------------------------------------------------------------------------
module ptmf_sorter import ptmf_pkg::*; (
  input  logic              clk_i,
  input  sort_ctrl_t        ctrl_i,
  input  logic [KLEN_W-1:0] klen_i,
  output sample_t           median_o
);

  sample_t     arr_q [SORT_N];
  sample_t     arr_d [SORT_N];
  logic [SORT_N-1:0] gt;
  logic [KLEN_W-1:0] pad;
  logic [SAMPLE_BITS:0] pair_sum;

  // Buffer is preloaded with pad zeros below and all-ones above. Each insert
  // drops the top entry, so after klen inserts the window's middle lands
  // on MID (odd length) or MID-1/MID (even length).
  always_comb begin
    pad = KLEN_W'((SORT_N - int'(klen_i)) >> 1);
    for (int j = 0; j < SORT_N; j++) begin
      gt[j] = (arr_q[j] > ctrl_i.val);
    end

    if (ctrl_i.init) begin
      for (int j = 0; j < SORT_N; j++) begin
        arr_d[j] = (j < int'(pad)) ? '0 : '1;
      end
    end else if (ctrl_i.ins) begin
      arr_d[0] = gt[0] ? ctrl_i.val : arr_q[0];
      for (int j = 1; j < SORT_N; j++) begin
        if (!gt[j]) begin
          arr_d[j] = arr_q[j];
        end else if (!gt[j-1]) begin
          arr_d[j] = ctrl_i.val;
        end else begin
          arr_d[j] = arr_q[j-1];
        end
      end
    end else begin
      for (int j = 0; j < SORT_N; j++) begin
        arr_d[j] = arr_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    arr_q <= arr_d;
  end

  assign pair_sum = {1'b0, arr_q[MID-1]} + {1'b0, arr_q[MID]};
  assign median_o = klen_i[0] ? arr_q[MID] : pair_sum[SAMPLE_BITS:1];

endmodule

// File: hw/rtl/per_bin_time_median_filter.sv
// ---------------------------------------------------------------------------
// per_bin_time_median_filter
// Per-bin median over the last kernel_len frames of spectrum magnitudes.
// ---------------------------------------------------------------------------
//  port     dir  payload                                   transfer
//  in_ch    in   magnitude[15:0]                           valid & ready
//  out_ch   out  median_value[15:0] bin_index[9:0] frame_end valid & ready
//  cfg      in   cfg_idx_i, cfg_wdata_i[10:0]               cfg_we_i
//
// Ready drops after a transfer and returns once the median is registered, so
// items never overlap: the history memory's single read port feeds
// the sort buffer one window entry per cycle. A result waits in the output
// register while the next item runs; a stalled output holds the sequencer at
// its final cycle. No clearing pass: a saturating count of completed frames
// marks unwritten history as zero, so the block is ready right after reset or
// a configuration write.
// ---------------------------------------------------------------------------
`include "per_bin_time_median_filter_macros.svh"

module per_bin_time_median_filter import ptmf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  ptmf_in_if.sink              in_ch,
  ptmf_out_if.source           out_ch
);

  state_e            state_q, state_d;
  logic [BIN_W-1:0]  bin_q, bin_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] fill_q, fill_d;
  logic [FS_W-1:0]   fs_q, fs_d;
  logic [KLEN_W-1:0] klen_q, klen_d;
  logic [KLEN_W-1:0] idx_q, idx_d;
  logic              first_q, first_d;
  logic              rdv_q, rdv_d;
  logic              zero_q, zero_d;
  sample_t           mag_q, mag_d;
  logic              out_valid_q, out_valid_d;
  sample_t           med_q, med_d;
  logic [BIN_W-1:0]  obin_q, obin_d;
  logic              oend_q, oend_d;

  logic              accept;
  logic              rd_en;
  logic              finish;
  logic              frame_last;
  logic [FS_W-1:0]   bin_next;
  logic [FS_W-1:0]   cfg_fs;
  logic [KLEN_W-1:0] cfg_klen;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  sample_t           rdata;
  sample_t           median;
  sort_ctrl_t        sort_ctrl;

  assign accept     = in_ch.valid && (state_q == S_IDLE);
  assign rd_en      = (state_q == S_RUN) && (idx_q < klen_q);
  assign bin_next   = FS_W'(bin_q) + FS_W'(1);
  assign frame_last = (bin_next >= fs_q);
  assign finish     = (state_q == S_RUN) && !rd_en && !rdv_q && !first_q &&
                      (!out_valid_q || out_ch.ready);

  assign waddr = {bin_q, slot_q};
  // ring walks backward from the slot written this frame
  assign raddr = {bin_q, slot_q - idx_q[SLOT_W-1:0]};

  always_comb begin
    cfg_fs = cfg_wdata_i[FS_W-1:0];
    if (cfg_fs < FS_MIN) begin
      cfg_fs = FS_MIN;
    end else if (cfg_fs > FS_MAX) begin
      cfg_fs = FS_MAX;
    end
    cfg_klen = cfg_wdata_i[KLEN_W-1:0];
    if (cfg_klen < KLEN_MIN) begin
      cfg_klen = KLEN_MIN;
    end else if (cfg_klen > KLEN_MAX) begin
      cfg_klen = KLEN_MAX;
    end
  end

  always_comb begin
    sort_ctrl.init = accept;
    sort_ctrl.ins  = first_q || rdv_q;
    sort_ctrl.val  = first_q ? mag_q : (zero_q ? '0 : rdata);
  end

  ptmf_hist_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (waddr),
    .wdata_i (in_ch.magnitude[SAMPLE_BITS-1:0]),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ptmf_sorter u_sort (
    .clk_i    (clk_i),
    .ctrl_i   (sort_ctrl),
    .klen_i   (klen_q),
    .median_o (median)
  );

  always_comb begin
    state_d     = state_q;
    bin_d       = bin_q;
    slot_d      = slot_q;
    fill_d      = fill_q;
    fs_d        = fs_q;
    klen_d      = klen_q;
    idx_d       = idx_q;
    first_d     = 1'b0;
    rdv_d       = rd_en;
    zero_d      = (idx_q > KLEN_W'(fill_q));
    mag_d       = mag_q;
    out_valid_d = out_valid_q;
    med_d       = med_q;
    obin_d      = obin_q;
    oend_d      = oend_q;

    if (out_valid_q && out_ch.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_RUN;
          first_d = 1'b1;
          mag_d   = in_ch.magnitude[SAMPLE_BITS-1:0];
          idx_d   = KLEN_W'(1);
        end
      end
      S_RUN: begin
        if (rd_en) begin
          idx_d = idx_q + KLEN_W'(1);
        end
        if (finish) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          med_d       = median;
          obin_d      = bin_q;
          oend_d      = frame_last;
          if (frame_last) begin
            bin_d  = '0;
            slot_d = slot_q + SLOT_W'(1);
            if (fill_q != SLOT_W'(MAX_KERNEL - 1)) begin
              fill_d = fill_q + SLOT_W'(1);
            end
          end else begin
            bin_d = bin_q + BIN_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // any register write restarts the history
    if (cfg_we_i && (cfg_idx_i == REG_FRAME_SIZE || cfg_idx_i == REG_KERNEL_LEN)) begin
      bin_d  = '0;
      slot_d = '0;
      fill_d = '0;
      if (cfg_idx_i == REG_FRAME_SIZE) begin
        fs_d = cfg_fs;
      end else begin
        klen_d = cfg_klen;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bin_q       <= '0;
      slot_q      <= '0;
      fill_q      <= '0;
      fs_q        <= FS_RESET;
      klen_q      <= KLEN_RESET;
      idx_q       <= '0;
      first_q     <= 1'b0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bin_q       <= bin_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      fs_q        <= fs_d;
      klen_q      <= klen_d;
      idx_q       <= idx_d;
      first_q     <= first_d;
      rdv_q       <= rdv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    mag_q  <= mag_d;
    med_q  <= med_d;
    obin_q <= obin_d;
    oend_q <= oend_d;
  end

  assign in_ch.ready         = (state_q == S_IDLE);
  assign out_ch.valid        = out_valid_q;
  assign out_ch.median_value = MAG_W'(med_q);
  assign out_ch.bin_index    = OBIN_W'(obin_q);
  assign out_ch.frame_end    = oend_q;

  `PTMF_ASSERT(a_bin_in_frame, FS_W'(bin_q) < fs_q, "bin counter beyond frame size")
  `PTMF_ASSERT_IMP(a_idle_no_insert, state_q == S_IDLE, !sort_ctrl.ins, "sort insert while idle")
  `PTMF_ASSERT_IMP(a_result_from_run, $rose(out_valid_q), $past(state_q) == S_RUN, "result without run")
  `PTMF_ASSERT_NEXT(a_frame_wrap, finish && frame_last && !cfg_we_i, bin_q == '0, "bin did not wrap")

endmodule
